// ===== hw/rtl/jse_pkg.sv =====
package jse_pkg;

    localparam int MAX_LEN = 64;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int NUM_W   = 3 * LEN_W + 3;
    localparam int SIM_W   = 17;
    localparam int CNT_W   = 7;
    localparam int DIV_STEPS = SIM_W;
    localparam int STEP_W  = $clog2(DIV_STEPS + 1);
    localparam logic [SIM_W-1:0] SIM_ONE = SIM_W'(65536);
    localparam logic [SIM_W-1:0] THRESHOLD_RESET = SIM_W'(62259);

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    typedef enum logic [1:0] {
        KIND_LOAD_A  = 2'd0,
        KIND_LOAD_B  = 2'd1,
        KIND_COMPUTE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_code;
    } item_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

// ===== hw/rtl/jse_ram.sv =====
module jse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/jse_front.sv =====
module jse_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       command,
    input  logic [7:0]       char_code,
    output logic             busy,
    output logic             item_valid,
    output jse_pkg::item_t   item,
    input  logic             item_pop
);

    jse_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    jse_pkg::item_t new_item;
    logic       known;

    always_comb
    begin
        known = 1'b1;
        new_item.char_code = char_code;
        new_item.kind = jse_pkg::KIND_COMPUTE;
        case (command)
            jse_pkg::CMD_LOAD_A:  new_item.kind = jse_pkg::KIND_LOAD_A;
            jse_pkg::CMD_LOAD_B:  new_item.kind = jse_pkg::KIND_LOAD_B;
            jse_pkg::CMD_COMPUTE: new_item.kind = jse_pkg::KIND_COMPUTE;
            default:              known = 1'b0;
        endcase
    end

    assign busy       = (count_reg == 2'd2);
    assign push       = start && !busy && known;
    assign item_valid = (count_reg != 2'd0);
    assign pop        = item_pop && item_valid;
    assign item       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/jse_back.sv =====
module jse_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  jse_pkg::item_t              item,
    output logic                        item_pop,
    input  logic                        threshold_we,
    input  logic [jse_pkg::SIM_W-1:0]   threshold_wdata,
    output jse_pkg::ram_req_t           ram_a,
    output jse_pkg::ram_req_t           ram_b,
    input  logic [7:0]                  rdata_a,
    input  logic [7:0]                  rdata_b,
    output logic                        done,
    output logic [jse_pkg::SIM_W-1:0]   similarity,
    output logic                        above_threshold,
    output logic [jse_pkg::CNT_W-1:0]   match_count,
    output logic [jse_pkg::CNT_W-1:0]   mismatch_pairs,
    output logic                        overflowed
);

    localparam int LW = jse_pkg::LEN_W;
    localparam int IW = jse_pkg::IDX_W;
    localparam int NW = jse_pkg::NUM_W;
    localparam int SW = jse_pkg::SIM_W;
    localparam int CW = jse_pkg::CNT_W;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_SETUP = 14'b00000000000010,
        ST_AREAD = 14'b00000000000100,
        ST_BINIT = 14'b00000000001000,
        ST_BREAD = 14'b00000000010000,
        ST_BCMP  = 14'b00000000100000,
        ST_TSCAN = 14'b00000001000000,
        ST_TSEEK = 14'b00000010000000,
        ST_TCMP  = 14'b00000100000000,
        ST_MUL1  = 14'b00001000000000,
        ST_MUL2  = 14'b00010000000000,
        ST_MUL3  = 14'b00100000000000,
        ST_DIV   = 14'b01000000000000,
        ST_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [SW-1:0] thr_reg, thr_next;
    logic [LW-1:0] len_a_reg, len_a_next, len_b_reg, len_b_next;
    logic          ovf_reg, ovf_next;
    logic [jse_pkg::MAX_LEN-1:0] mark_a_reg, mark_a_next, mark_b_reg, mark_b_next;
    logic [LW-1:0] i_reg, i_next, j_reg, j_next, hi_reg, hi_next, p_reg, p_next;
    logic [LW-1:0] m_reg, m_next, x_reg, x_next;
    logic signed [LW+1:0] win_reg, win_next;
    logic [2*LW-1:0] mm_reg, mm_next, ab_reg, ab_next;
    logic [LW:0]     sab_reg, sab_next, tx_reg, tx_next;
    logic [NW-1:0]   t1_reg, t1_next, t2_reg, t2_next, abm_reg, abm_next;
    logic [NW-1:0]   den_reg, den_next;
    logic [NW:0]     rem_reg, rem_next;
    logic [SW-1:0]   q_reg, q_next;
    logic [jse_pkg::STEP_W-1:0] step_reg, step_next;
    logic            done_reg, done_next;
    logic [SW-1:0]   sim_reg, sim_next;
    logic            above_reg, above_next;
    logic [CW-1:0]   mc_reg, mc_next, mp_reg, mp_next;
    logic            ovo_reg, ovo_next;

    logic signed [LW+1:0] lo_s, hi_s;
    logic [LW-1:0]        maxl;
    logic [NW:0]          trial;
    logic [NW:0]          diff;
    logic [LW-1:0]        i_inc;
    logic [SW-1:0]        sim_final;

    assign i_inc = i_reg + LW'(1);
    assign maxl  = (len_a_reg > len_b_reg) ? len_a_reg : len_b_reg;
    assign lo_s  = $signed({2'b00, i_reg}) - win_reg;
    assign hi_s  = $signed({2'b00, i_reg}) + win_reg;
    assign trial = (step_reg == '0) ? rem_reg : {rem_reg[NW-1:0], 1'b0};
    assign diff  = trial - {1'b0, den_reg};
    assign sim_final = (m_reg == '0) ? '0 :
                       ((q_reg > jse_pkg::SIM_ONE) ? jse_pkg::SIM_ONE : q_reg);

    always_comb
    begin
        state_next  = state_reg;
        thr_next    = threshold_we ? threshold_wdata : thr_reg;
        len_a_next  = len_a_reg;
        len_b_next  = len_b_reg;
        ovf_next    = ovf_reg;
        mark_a_next = mark_a_reg;
        mark_b_next = mark_b_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        hi_next     = hi_reg;
        p_next      = p_reg;
        m_next      = m_reg;
        x_next      = x_reg;
        win_next    = win_reg;
        mm_next     = mm_reg;
        ab_next     = ab_reg;
        sab_next    = sab_reg;
        tx_next     = tx_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        abm_next    = abm_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        sim_next    = sim_reg;
        above_next  = above_reg;
        mc_next     = mc_reg;
        mp_next     = mp_reg;
        ovo_next    = ovo_reg;
        item_pop    = 1'b0;
        ram_a       = '0;
        ram_b       = '0;
        ram_a.wdata = item.char_code;
        ram_b.wdata = item.char_code;
        ram_a.waddr = len_a_reg[IW-1:0];
        ram_b.waddr = len_b_reg[IW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    case (item.kind)
                        jse_pkg::KIND_LOAD_A:
                        begin
                            if (len_a_reg < LW'(jse_pkg::MAX_LEN))
                            begin
                                ram_a.we   = 1'b1;
                                len_a_next = len_a_reg + LW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        jse_pkg::KIND_LOAD_B:
                        begin
                            if (len_b_reg < LW'(jse_pkg::MAX_LEN))
                            begin
                                ram_b.we   = 1'b1;
                                len_b_next = len_b_reg + LW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_SETUP;
                        end
                    endcase
                end
            end
            ST_SETUP:
            begin
                m_next   = '0;
                x_next   = '0;
                q_next   = '0;
                i_next   = '0;
                win_next = $signed({3'b000, maxl[LW-1:1]}) - (LW+2)'(1);
                if (len_a_reg == '0 || len_b_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_AREAD;
                end
            end
            ST_AREAD:
            begin
                ram_a.re    = 1'b1;
                ram_a.raddr = i_reg[IW-1:0];
                state_next  = ST_BINIT;
            end
            ST_BINIT:
            begin
                j_next  = (lo_s < 0) ? '0 : lo_s[LW-1:0];
                hi_next = (hi_s > $signed({2'b00, len_b_reg}) - (LW+2)'(1)) ?
                          (len_b_reg - LW'(1)) : hi_s[LW-1:0];
                if (win_reg < 0 || lo_s >= $signed({2'b00, len_b_reg}))
                begin
                    i_next = i_inc;
                    if (i_inc == len_a_reg)
                    begin
                        i_next     = '0;
                        p_next     = '0;
                        state_next = ST_TSCAN;
                    end
                    else
                    begin
                        state_next = ST_AREAD;
                    end
                end
                else
                begin
                    state_next = ST_BREAD;
                end
            end
            ST_BREAD:
            begin
                ram_b.re    = 1'b1;
                ram_b.raddr = j_reg[IW-1:0];
                state_next  = ST_BCMP;
            end
            ST_BCMP:
            begin
                if (!mark_b_reg[j_reg[IW-1:0]] && rdata_b == rdata_a)
                begin
                    mark_a_next[i_reg[IW-1:0]] = 1'b1;
                    mark_b_next[j_reg[IW-1:0]] = 1'b1;
                    m_next = m_reg + LW'(1);
                end
                if ((!mark_b_reg[j_reg[IW-1:0]] && rdata_b == rdata_a) || j_reg == hi_reg)
                begin
                    i_next = i_inc;
                    if (i_inc == len_a_reg)
                    begin
                        i_next     = '0;
                        p_next     = '0;
                        state_next = ST_TSCAN;
                    end
                    else
                    begin
                        state_next = ST_AREAD;
                    end
                end
                else
                begin
                    j_next     = j_reg + LW'(1);
                    state_next = ST_BREAD;
                end
            end
            ST_TSCAN:
            begin
                if (i_reg == len_a_reg)
                begin
                    state_next = ST_MUL1;
                end
                else if (mark_a_reg[i_reg[IW-1:0]])
                begin
                    ram_a.re    = 1'b1;
                    ram_a.raddr = i_reg[IW-1:0];
                    state_next  = ST_TSEEK;
                end
                else
                begin
                    i_next = i_inc;
                end
            end
            ST_TSEEK:
            begin
                if (p_reg == len_b_reg)
                begin
                    i_next     = i_inc;
                    state_next = ST_TSCAN;
                end
                else if (mark_b_reg[p_reg[IW-1:0]])
                begin
                    ram_b.re    = 1'b1;
                    ram_b.raddr = p_reg[IW-1:0];
                    state_next  = ST_TCMP;
                end
                else
                begin
                    p_next = p_reg + LW'(1);
                end
            end
            ST_TCMP:
            begin
                if (rdata_a != rdata_b)
                begin
                    x_next = x_reg + LW'(1);
                end
                p_next     = p_reg + LW'(1);
                i_next     = i_inc;
                state_next = ST_TSCAN;
            end
            ST_MUL1:
            begin
                mm_next    = (2*LW)'(m_reg) * (2*LW)'(m_reg);
                ab_next    = (2*LW)'(len_a_reg) * (2*LW)'(len_b_reg);
                sab_next   = (LW+1)'(len_a_reg) + (LW+1)'(len_b_reg);
                tx_next    = {m_reg, 1'b0} - (LW+1)'(x_reg);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                t1_next    = (NW'(mm_reg) * NW'(sab_reg)) << 1;
                t2_next    = NW'(ab_reg) * NW'(tx_reg);
                abm_next   = NW'(ab_reg) * NW'(m_reg);
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                rem_next   = (NW+1)'(t1_reg) + (NW+1)'(t2_reg);
                den_next   = (abm_reg << 2) + (abm_reg << 1);
                step_next  = '0;
                state_next = (m_reg == '0) ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (!diff[NW])
                begin
                    rem_next = diff;
                end
                else
                begin
                    rem_next = trial;
                end
                q_next    = {q_reg[SW-2:0], !diff[NW]};
                step_next = step_reg + jse_pkg::STEP_W'(1);
                if (step_reg == jse_pkg::STEP_W'(jse_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done_next   = 1'b1;
                sim_next    = sim_final;
                above_next  = (sim_final >= thr_reg);
                mc_next     = CW'(m_reg);
                mp_next     = CW'(x_reg);
                ovo_next    = ovf_reg;
                len_a_next  = '0;
                len_b_next  = '0;
                ovf_next    = 1'b0;
                mark_a_next = '0;
                mark_b_next = '0;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        hi_reg  <= hi_next;
        p_reg   <= p_next;
        m_reg   <= m_next;
        x_reg   <= x_next;
        win_reg <= win_next;
        mm_reg  <= mm_next;
        ab_reg  <= ab_next;
        sab_reg <= sab_next;
        tx_reg  <= tx_next;
        t1_reg  <= t1_next;
        t2_reg  <= t2_next;
        abm_reg <= abm_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        step_reg <= step_next;
        sim_reg  <= sim_next;
        above_reg <= above_next;
        mc_reg   <= mc_next;
        mp_reg   <= mp_next;
        ovo_reg  <= ovo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            thr_reg    <= jse_pkg::THRESHOLD_RESET;
            len_a_reg  <= '0;
            len_b_reg  <= '0;
            ovf_reg    <= 1'b0;
            mark_a_reg <= '0;
            mark_b_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            thr_reg    <= thr_next;
            len_a_reg  <= len_a_next;
            len_b_reg  <= len_b_next;
            ovf_reg    <= ovf_next;
            mark_a_reg <= mark_a_next;
            mark_b_reg <= mark_b_next;
            done_reg   <= done_next;
        end
    end

    assign done            = done_reg;
    assign similarity      = sim_reg;
    assign above_threshold = above_reg;
    assign match_count     = mc_reg;
    assign mismatch_pairs  = mp_reg;
    assign overflowed      = ovo_reg;

endmodule

// ===== hw/rtl/jaro_similarity_engine.sv =====
// Channel   Handshake            Beat contents
// command   start / busy         command, char_code
// config    threshold_we         threshold_wdata (accept_threshold)
// result    done (one cycle)     similarity, above_threshold, match_count,
//                                mismatch_pairs, overflowed
// Loads reach the back end at one beat per cycle while it is idle; a compute holds them back.
// A compute runs a setup step, reads each character of A and compares it with B across
// its match window, then a transposition scan, multiply steps, a restoring divider and
// a step that posts the result; an empty string or no matches skips ahead to that step.
// A two-entry queue holds further commands during a compute; busy is high when it is full.
// Reset clears lengths, match marks, the overflow flag and the threshold to 0.95.
// The result strobe cannot be stalled by the receiver.
module jaro_similarity_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  command,
    input  logic [7:0]                  char_code,
    input  logic                        threshold_we,
    input  logic [jse_pkg::SIM_W-1:0]   threshold_wdata,
    output logic                        done,
    output logic [jse_pkg::SIM_W-1:0]   similarity,
    output logic                        above_threshold,
    output logic [jse_pkg::CNT_W-1:0]   match_count,
    output logic [jse_pkg::CNT_W-1:0]   mismatch_pairs,
    output logic                        overflowed
);

    logic              item_valid;
    logic              item_pop;
    jse_pkg::item_t    item;
    jse_pkg::ram_req_t ram_a;
    jse_pkg::ram_req_t ram_b;
    logic [7:0]        rdata_a;
    logic [7:0]        rdata_b;

    jse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .char_code  (char_code),
        .busy       (busy),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    jse_ram #(.WIDTH(8), .DEPTH(jse_pkg::MAX_LEN)) u_ram_a (
        .clk   (clk),
        .we    (ram_a.we),
        .waddr (ram_a.waddr),
        .wdata (ram_a.wdata),
        .re    (ram_a.re),
        .raddr (ram_a.raddr),
        .rdata (rdata_a)
    );

    jse_ram #(.WIDTH(8), .DEPTH(jse_pkg::MAX_LEN)) u_ram_b (
        .clk   (clk),
        .we    (ram_b.we),
        .waddr (ram_b.waddr),
        .wdata (ram_b.wdata),
        .re    (ram_b.re),
        .raddr (ram_b.raddr),
        .rdata (rdata_b)
    );

    jse_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item            (item),
        .item_pop        (item_pop),
        .threshold_we    (threshold_we),
        .threshold_wdata (threshold_wdata),
        .ram_a           (ram_a),
        .ram_b           (ram_b),
        .rdata_a         (rdata_a),
        .rdata_b         (rdata_b),
        .done            (done),
        .similarity      (similarity),
        .above_threshold (above_threshold),
        .match_count     (match_count),
        .mismatch_pairs  (mismatch_pairs),
        .overflowed      (overflowed)
    );

endmodule

// ===== hw/rtl/jse_checker.sv =====
module jse_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        done,
    input logic [jse_pkg::SIM_W-1:0]   similarity,
    input logic [jse_pkg::CNT_W-1:0]   match_count,
    input logic [jse_pkg::CNT_W-1:0]   mismatch_pairs
);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe held for two cycles.");

    a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> similarity <= jse_pkg::SIM_ONE)
        else $error("Similarity above one.");

    a_zero_match: assert property (@(posedge clk) disable iff (!rst_n)
        done && match_count == '0 |-> similarity == '0 && mismatch_pairs == '0)
        else $error("Nonzero result without matches.");

    a_pairs_le_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> mismatch_pairs <= match_count)
        else $error("More mismatched pairs than matches.");

endmodule

bind jaro_similarity_engine jse_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .done           (done),
    .similarity     (similarity),
    .match_count    (match_count),
    .mismatch_pairs (mismatch_pairs)
);

// ===== dv/jaro_similarity_engine_test.sv =====
module jaro_similarity_engine_test;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [jse_pkg::SIM_W-1:0] sim;
        logic                      above;
        logic [jse_pkg::CNT_W-1:0] match_cnt;
        logic [jse_pkg::CNT_W-1:0] pairs;
        logic                      ovf;
    } jaro_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [1:0]                   command;
    logic [7:0]                   char_code;
    logic                         threshold_we;
    logic [jse_pkg::SIM_W-1:0]    threshold_wdata;
    logic                         done;
    logic [jse_pkg::SIM_W-1:0]    similarity;
    logic                         above_threshold;
    logic [jse_pkg::CNT_W-1:0]    match_count;
    logic [jse_pkg::CNT_W-1:0]    mismatch_pairs;
    logic                         overflowed;

    logic [7:0]                   str_a [jse_pkg::MAX_LEN];
    logic [7:0]                   str_b [jse_pkg::MAX_LEN];
    int unsigned                  len_a;
    int unsigned                  len_b;
    logic                         ovf_seen;
    logic [jse_pkg::SIM_W-1:0]    accept_thr;
    jaro_result_t                 pending_scores [$];
    int                           fail_count;
    int                           items_sent;

    jaro_similarity_engine i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .char_code       (char_code),
        .threshold_we    (threshold_we),
        .threshold_wdata (threshold_wdata),
        .done            (done),
        .similarity      (similarity),
        .above_threshold (above_threshold),
        .match_count     (match_count),
        .mismatch_pairs  (mismatch_pairs),
        .overflowed      (overflowed)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic score_strings();
        jaro_result_t r;
        logic         ma [jse_pkg::MAX_LEN];
        logic         mb [jse_pkg::MAX_LEN];
        int           win;
        int           lo;
        int           hi;
        int           p;
        longint unsigned m;
        longint unsigned x;
        longint unsigned num;
        longint unsigned den;
        longint unsigned sim;
        m = 0;
        x = 0;
        sim = 0;
        for (int k = 0; k < jse_pkg::MAX_LEN; k++)
        begin
            ma[k] = 1'b0;
            mb[k] = 1'b0;
        end
        if (len_a != 0 && len_b != 0)
        begin
            win = int'((len_a > len_b) ? len_a : len_b) / 2 - 1;
            for (int i = 0; i < len_a; i++)
            begin
                lo = (i - win < 0) ? 0 : i - win;
                hi = (i + win > int'(len_b) - 1) ? int'(len_b) - 1 : i + win;
                for (int j = lo; j <= hi; j++)
                begin
                    if (!mb[j] && str_b[j] == str_a[i])
                    begin
                        ma[i] = 1'b1;
                        mb[j] = 1'b1;
                        m++;
                        break;
                    end
                end
            end
            p = 0;
            for (int i = 0; i < len_a; i++)
            begin
                if (ma[i])
                begin
                    while (p < len_b && !mb[p])
                        p++;
                    if (p < len_b)
                    begin
                        if (str_a[i] != str_b[p])
                            x++;
                        p++;
                    end
                end
            end
            if (m != 0)
            begin
                num = 2 * m * m * (len_a + len_b) + len_a * len_b * (2 * m - x);
                den = 6 * len_a * len_b * m;
                sim = (num << 16) / den;
                if (sim > 65536)
                    sim = 65536;
            end
        end
        r.sim = sim[jse_pkg::SIM_W-1:0];
        r.above = (sim >= accept_thr);
        r.match_cnt = m[jse_pkg::CNT_W-1:0];
        r.pairs = x[jse_pkg::CNT_W-1:0];
        r.ovf = ovf_seen;
        pending_scores.insert(pending_scores.size(), r);
        len_a = 0;
        len_b = 0;
        ovf_seen = 1'b0;
    endtask

    task automatic predict(input logic [1:0] cmd, input logic [7:0] ch);
        if (cmd == jse_pkg::CMD_LOAD_A)
        begin
            if (len_a < jse_pkg::MAX_LEN)
            begin
                str_a[len_a] = ch;
                len_a++;
            end
            else
                ovf_seen = 1'b1;
        end
        else if (cmd == jse_pkg::CMD_LOAD_B)
        begin
            if (len_b < jse_pkg::MAX_LEN)
            begin
                str_b[len_b] = ch;
                len_b++;
            end
            else
                ovf_seen = 1'b1;
        end
        else if (cmd == jse_pkg::CMD_COMPUTE)
            score_strings();
    endtask

    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] ch);
        int gap;
        int roll;
        @(negedge clk);
        start = 1'b1;
        command = cmd;
        char_code = ch;
        do
            @(posedge clk);
        while (busy);
        predict(cmd, ch);
        items_sent++;
        roll = $urandom_range(0, 99);
        gap = (roll < 60) ? 0 : (roll < 93) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            command = 2'($urandom);
            char_code = 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending_scores.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [jse_pkg::SIM_W-1:0] value);
        wait_drained();
        threshold_we = 1'b1;
        threshold_wdata = value;
        accept_thr = value;
        @(negedge clk);
        threshold_we = 1'b0;
        threshold_wdata = jse_pkg::SIM_W'($urandom);
    endtask

    task automatic send_pair(input string sa, input string sb);
        for (int i = 0; i < sa.len(); i++)
            send_beat(jse_pkg::CMD_LOAD_A, sa[i]);
        for (int i = 0; i < sb.len(); i++)
            send_beat(jse_pkg::CMD_LOAD_B, sb[i]);
        send_beat(jse_pkg::CMD_COMPUTE, 8'($urandom));
    endtask

    task automatic test_special_cases();
        send_pair("", "");
        send_pair("AB", "");
        send_pair("a", "a");
        send_pair("MARTHA", "MARHTA");
        send_pair("abc", "xyz");
        send_beat(jse_pkg::CMD_LOAD_A, 8'h00);
        send_beat(jse_pkg::CMD_LOAD_B, 8'hFF);
        send_beat(CMD_UNUSED, 8'hA5);
        send_beat(jse_pkg::CMD_COMPUTE, 8'h00);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < jse_pkg::MAX_LEN + 2; i++)
            send_beat(jse_pkg::CMD_LOAD_A, 8'(8'h41 + i % 3));
        send_pair("ABC", "BAC");
        for (int i = 0; i < jse_pkg::MAX_LEN + 1; i++)
            send_beat(jse_pkg::CMD_LOAD_B, 8'(8'h41 + i % 2));
        send_pair("", "");
    endtask

    task automatic test_thresholds();
        logic [jse_pkg::SIM_W-1:0] levels [5];
        levels = '{jse_pkg::SIM_W'(0), jse_pkg::SIM_ONE, jse_pkg::SIM_W'(131071),
                   jse_pkg::SIM_W'(40000), jse_pkg::THRESHOLD_RESET};
        foreach (levels[k])
        begin
            write_threshold(levels[k]);
            send_pair("DIXON", "DICKSONX");
            send_pair("abcd", "abcd");
            send_pair("", "q");
        end
    endtask

    task automatic send_random_pair();
        logic [7:0] a [$];
        logic [7:0] b [$];
        logic [7:0] t;
        int         na;
        int         nb;
        int         k;
        int         ia;
        int         ib;
        int         alpha;
        na = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 10);
        alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 6);
        for (int i = 0; i < na; i++)
            a.insert(a.size(), (alpha == 256) ? 8'($urandom) :
                8'(8'h60 + $urandom_range(0, alpha - 1)));
        b = a;
        repeat ($urandom_range(0, 3))
        begin
            if (b.size() > 1)
            begin
                k = $urandom_range(0, b.size() - 2);
                t = b[k];
                b[k] = b[k + 1];
                b[k + 1] = t;
            end
        end
        if ($urandom_range(0, 2) == 0)
            b.insert(b.size(), 8'($urandom));
        if ($urandom_range(0, 3) == 0 && b.size() > 0)
            b.delete($urandom_range(0, b.size() - 1));
        if ($urandom_range(0, 9) == 0)
            b = {};
        nb = b.size();
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb)
        begin
            if ($urandom_range(0, 24) == 0)
                send_beat(CMD_UNUSED, 8'($urandom));
            else if (ib >= nb || (ia < na && $urandom_range(0, 1)))
            begin
                send_beat(jse_pkg::CMD_LOAD_A, a[ia]);
                ia++;
            end
            else
            begin
                send_beat(jse_pkg::CMD_LOAD_B, b[ib]);
                ib++;
            end
        end
        send_beat(jse_pkg::CMD_COMPUTE, 8'($urandom));
        if ($urandom_range(0, 29) == 0)
            wait_drained();
    endtask

    task automatic test_random();
        int phase_end;
        phase_end = items_sent + 400;
        while (items_sent < 1900)
        begin
            send_random_pair();
            if (items_sent >= phase_end)
            begin
                write_threshold(jse_pkg::SIM_W'($urandom_range(0, 65536)));
                phase_end = items_sent + 400;
            end
        end
    endtask

    always @(posedge clk)
    begin
        jaro_result_t e;
        if (rst_n && done)
        begin
            if (pending_scores.size() == 0)
            begin
                $error("unexpected result beat");
                fail_count++;
            end
            else
            begin
                e = pending_scores.pop_front();
                if (similarity !== e.sim)
                begin
                    $error("similarity expected %0d actual %0d", e.sim, similarity);
                    fail_count++;
                end
                if (above_threshold !== e.above)
                begin
                    $error("above_threshold expected %0d actual %0d", e.above,
                        above_threshold);
                    fail_count++;
                end
                if (match_count !== e.match_cnt)
                begin
                    $error("match_count expected %0d actual %0d", e.match_cnt,
                        match_count);
                    fail_count++;
                end
                if (mismatch_pairs !== e.pairs)
                begin
                    $error("mismatch_pairs expected %0d actual %0d", e.pairs,
                        mismatch_pairs);
                    fail_count++;
                end
                if (overflowed !== e.ovf)
                begin
                    $error("overflowed expected %0d actual %0d", e.ovf, overflowed);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #400000000;
        $display("jaro_similarity_engine verification failed");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        command = jse_pkg::CMD_LOAD_A;
        char_code = 8'h00;
        threshold_we = 1'b0;
        threshold_wdata = '0;
        len_a = 0;
        len_b = 0;
        ovf_seen = 1'b0;
        accept_thr = jse_pkg::THRESHOLD_RESET;
        fail_count = 0;
        items_sent = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        test_special_cases();
        test_overflow();
        test_thresholds();
        test_random();
        wait_drained();
        if (fail_count == 0)
            $display("jaro_similarity_engine verification clean");
        else
            $display("jaro_similarity_engine verification failed");
        $finish;
    end

endmodule
